// ===== hdl/robin_hood_hash_table_assert.svh =====
// Assertion macros for the robin hood hash table.
// Included by modules that check their own sequencing.
`ifndef ROBIN_HOOD_HASH_TABLE_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_ASSERT_SVH

// implication checked on every clock, off during reset
`define RH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rhht_pkg.sv =====
// Package for the robin hood hash table: sizes, codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package rhht_pkg;
    localparam int SLOTS      = 1024;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = 11;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_KEY = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_PLACE_RD,
        S_PLACE_CHK,
        S_SHIFT_RD,
        S_SHIFT_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] span;
    } slot_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        slot_t            wdata;
    } slot_wr_t;
endpackage

// ===== hdl/rhht_store.sv =====
// Slot memory for the robin hood hash table: valid, key, value, distance per
// slot; valid bits are cleared by the sequencer after reset. Uses rhht_pkg.
`timescale 1ns / 1ps
module rhht_store (
    input  logic                       clk,
    input  logic [rhht_pkg::IDX_W-1:0] raddr,
    input  rhht_pkg::slot_wr_t         wr,
    output rhht_pkg::slot_t            rdata
);
    import rhht_pkg::*;

    slot_t mem [SLOTS];
    slot_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.waddr] <= wr.wdata;
        end
        rd_reg <= mem[raddr];
    end

    assign rdata = rd_reg;
endmodule

// ===== hdl/rhht_seq.sv =====
// Probe sequencer: walks slots one per read/check pair for find, Robin Hood
// placement and backward-shift delete. Uses rhht_pkg and the assert header.
`timescale 1ns / 1ps
`include "robin_hood_hash_table_assert.svh"
module rhht_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [1:0]                   action,
    input  logic [rhht_pkg::KEY_W-1:0]   key,
    input  logic [rhht_pkg::VAL_W-1:0]   value,
    input  logic [rhht_pkg::CNT_W-1:0]   max_entries,
    input  rhht_pkg::slot_t              rdata,
    output logic [rhht_pkg::IDX_W-1:0]   raddr,
    output rhht_pkg::slot_wr_t           wr,
    output logic                         busy,
    output logic                         done,
    output logic                         found,
    output logic [rhht_pkg::VAL_W-1:0]   data_out,
    output logic [1:0]                   status,
    output logic [rhht_pkg::CNT_W-1:0]   entry_count
);
    import rhht_pkg::*;

    state_t            state_reg, state_next;
    logic [1:0]        act_reg, act_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]  val_reg, val_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  span_reg, span_next;
    logic [IDX_W:0]    steps_reg, steps_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  longest_reg, longest_next;
    logic              found_reg, found_next;
    logic [VAL_W-1:0]  data_reg, data_next;
    logic [1:0]        status_reg, status_next;
    logic [IDX_W-1:0]  pos_inc;
    logic              at_limit;
    logic              hit;
    logic              shift_stop;

    assign pos_inc    = pos_reg + IDX_W'(1);
    assign at_limit   = (count_reg >= max_entries) || (count_reg >= CNT_W'(SLOTS));
    assign hit        = rdata.valid && (rdata.key == key_reg);
    assign shift_stop = !rdata.valid || rdata.span == '0 ||
                        steps_reg == (IDX_W+1)'(SLOTS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            pos_reg     <= '0;
            count_reg   <= '0;
            longest_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            longest_reg <= longest_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        span_reg   <= span_next;
        steps_reg  <= steps_next;
        found_reg  <= found_next;
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (pos_reg == IDX_W'(SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_NONE || key == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_FIND_RD;
                end
            end
            S_FIND_RD:   state_next = S_FIND_CHK;
            S_FIND_CHK:
            begin
                if (hit)
                begin
                    state_next = (act_reg == ACT_REMOVE) ? S_SHIFT_RD : S_DONE;
                end
                else if (!rdata.valid || steps_reg == (IDX_W+1)'(SLOTS - 1))
                begin
                    if (act_reg == ACT_INSERT && !at_limit)
                        state_next = S_PLACE_RD;
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FIND_RD;
                end
            end
            S_PLACE_RD:  state_next = S_PLACE_CHK;
            S_PLACE_CHK:
            begin
                if (!rdata.valid || steps_reg == (IDX_W+1)'(SLOTS - 1))
                    state_next = S_DONE;
                else
                    state_next = S_PLACE_RD;
            end
            S_SHIFT_RD:  state_next = S_SHIFT_CHK;
            S_SHIFT_CHK:
            begin
                if (shift_stop)
                    state_next = S_DONE;
                else
                    state_next = S_SHIFT_RD;
            end
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        act_next     = act_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        pos_next     = pos_reg;
        span_next    = span_reg;
        steps_next   = steps_reg;
        count_next   = count_reg;
        longest_next = longest_reg;
        found_next   = found_reg;
        data_next    = data_reg;
        status_next  = status_reg;
        raddr        = pos_reg;
        wr           = '0;
        case (state_reg)
            S_CLEAR:
            begin
                wr.we    = 1'b1;
                wr.waddr = pos_reg;
                pos_next = pos_inc;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    act_next    = action;
                    key_next    = key;
                    val_next    = value;
                    pos_next    = key[IDX_W-1:0];
                    span_next   = '0;
                    steps_next  = '0;
                    found_next  = 1'b0;
                    data_next   = '0;
                    status_next = (action != ACT_NONE && key == '0) ? ST_BAD_KEY : ST_OK;
                end
            end
            S_FIND_RD:
            begin
                raddr = pos_reg;
            end
            S_FIND_CHK:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    if (act_reg == ACT_INSERT)
                    begin
                        wr.we    = 1'b1;
                        wr.waddr = pos_reg;
                        wr.wdata = rdata;
                        wr.wdata.value = val_reg;
                        if (rdata.span > longest_reg)
                            longest_next = rdata.span;
                    end
                    else if (act_reg == ACT_LOOKUP)
                    begin
                        data_next = rdata.value;
                    end
                    else
                    begin
                        steps_next = '0;
                        span_next  = '0;
                        pos_next   = pos_reg;
                        val_next   = '0;
                    end
                end
                else if (!rdata.valid || steps_reg == (IDX_W+1)'(SLOTS - 1))
                begin
                    if (act_reg == ACT_INSERT)
                    begin
                        if (at_limit)
                            status_next = ST_FULL;
                        pos_next   = key_reg[IDX_W-1:0];
                        span_next  = '0;
                        steps_next = '0;
                    end
                end
                else
                begin
                    pos_next   = pos_inc;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_PLACE_RD:
            begin
                raddr = pos_reg;
            end
            S_PLACE_CHK:
            begin
                if (!rdata.valid)
                begin
                    wr.we          = 1'b1;
                    wr.waddr       = pos_reg;
                    wr.wdata.valid = 1'b1;
                    wr.wdata.key   = key_reg;
                    wr.wdata.value = val_reg;
                    wr.wdata.span  = span_reg;
                    if (span_reg > longest_reg)
                        longest_next = span_reg;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    if (rdata.span < span_reg)
                    begin
                        wr.we          = 1'b1;
                        wr.waddr       = pos_reg;
                        wr.wdata.valid = 1'b1;
                        wr.wdata.key   = key_reg;
                        wr.wdata.value = val_reg;
                        wr.wdata.span  = span_reg;
                        if (span_reg > longest_reg)
                            longest_next = span_reg;
                        key_next  = rdata.key;
                        val_next  = rdata.value;
                        span_next = rdata.span + IDX_W'(1);
                    end
                    else
                    begin
                        span_next = span_reg + IDX_W'(1);
                    end
                    pos_next   = pos_inc;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_SHIFT_RD:
            begin
                raddr = pos_inc;
            end
            S_SHIFT_CHK:
            begin
                wr.we    = 1'b1;
                wr.waddr = pos_reg;
                if (shift_stop)
                begin
                    // vacate the last slot of the run
                    if (count_reg != '0)
                        count_next = count_reg - 1'b1;
                end
                else
                begin
                    wr.wdata.valid = 1'b1;
                    wr.wdata.key   = rdata.key;
                    wr.wdata.value = rdata.value;
                    wr.wdata.span  = rdata.span - IDX_W'(1);
                    pos_next       = pos_inc;
                    steps_next     = steps_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != S_IDLE);
        done        = (state_reg == S_DONE);
        found       = found_reg;
        data_out    = data_reg;
        status      = status_reg;
        entry_count = count_reg;
    end

    `RH_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "start did not raise busy")
    `RH_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy, "done not followed by idle")
    `RH_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CNT_W'(SLOTS), "count above slots")
    `RH_ASSERT_NEXT(a_count_step, clk, rst_n, !done && state_reg != S_PLACE_CHK && state_reg != S_SHIFT_CHK, $stable(count_reg), "count changed outside an update")
endmodule

// ===== hdl/robin_hood_hash_table.sv =====
// Robin hood hash table, 1024 slots, with backward-shift delete.
// Top level; instantiates rhht_seq and rhht_store, uses rhht_pkg.
// After reset busy stays high while the slot memory's valid bits are cleared,
// one slot per cycle. Raise start while busy is low with action, key and
// value; the block visits each slot as one memory read, then one compare,
// through a slot memory with one read and one write port.
// An operation visits slots in find probes, then placement or shift slots,
// then passes through a done state and an idle state before the next word is
// taken; a bad key or unknown action goes straight from idle to done.
// done is high for one cycle with found, data_out, status and entry_count;
// the receiver cannot stall, so sample them in that cycle.
`timescale 1ns / 1ps
module robin_hood_hash_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  action,
    input  logic [rhht_pkg::KEY_W-1:0]  key,
    input  logic [rhht_pkg::VAL_W-1:0]  value,
    input  logic                        cfg_we,
    input  logic [rhht_pkg::CNT_W-1:0]  cfg_wdata,
    output logic                        done,
    output logic                        found,
    output logic [rhht_pkg::VAL_W-1:0]  data_out,
    output logic [1:0]                  status,
    output logic [rhht_pkg::CNT_W-1:0]  entry_count
);
    import rhht_pkg::*;

    logic [CNT_W-1:0] max_entries_reg;
    logic [IDX_W-1:0] raddr;
    slot_wr_t         wr;
    slot_t            rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_entries_reg <= CNT_W'(768);
        else if (cfg_we)
            max_entries_reg <= cfg_wdata;
    end

    rhht_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .key         (key),
        .value       (value),
        .max_entries (max_entries_reg),
        .rdata       (rdata),
        .raddr       (raddr),
        .wr          (wr),
        .busy        (busy),
        .done        (done),
        .found       (found),
        .data_out    (data_out),
        .status      (status),
        .entry_count (entry_count)
    );

    rhht_store u_store (
        .clk   (clk),
        .raddr (raddr),
        .wr    (wr),
        .rdata (rdata)
    );
endmodule
